/* src/command_line_assembler_assert.svh */
`ifndef COMMAND_LINE_ASSEMBLER_ASSERT_SVH
`define COMMAND_LINE_ASSEMBLER_ASSERT_SVH

// check a condition on every clock edge outside reset
`define CLA_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// check a consequent in the same cycle as its antecedent
`define CLA_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// check a consequent in the cycle after its antecedent
`define CLA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* src/cla_pkg.sv */
package cla_pkg;

  localparam int LINE_SIZE_DEF = 64;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_QUERY = 8'h3F;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_ERR  = 1'b1;

endpackage

/* src/cla_ram.sv */
module cla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = cla_pkg::LINE_SIZE_DEF,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

/* src/command_line_assembler.sv */
// A completing byte starts streaming the line; an over-long byte registers
// its error result. Bytes are taken one per cycle while no line streams and
// no result is pending; a line streams at one character per cycle, unless
// the receiver stalls, from the single read port of the line store.
// Reset (rst_n low, synchronous) empties the line and clears the skip flag.
module command_line_assembler #(
  parameter int LINE_SIZE = cla_pkg::LINE_SIZE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_kind,
  output logic [7:0] out_line_char,
  output logic       out_last
);

  localparam int LEN_W = $clog2(LINE_SIZE);
  localparam logic [LEN_W-1:0] LAST_IDX = LEN_W'(LINE_SIZE - 1);
  localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_STREAM = 1'b1;

  logic             state_r, state_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             skip_r, skip_nxt;
  logic [LEN_W-1:0] idx_r, idx_nxt;
  logic [LEN_W-1:0] n_r, n_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             kind_r, kind_nxt;
  logic             last_r, last_nxt;

  logic             in_xfer;
  logic             is_end;
  logic             is_erase;
  logic             wr_en;
  logic             rd_en;
  logic [7:0]       rd_data;

  assign in_stall      = (state_r != ST_IDLE) || out_valid_r;
  assign in_xfer       = in_valid && !in_stall;
  assign out_valid     = out_valid_r;
  assign out_kind      = kind_r;
  assign out_last      = last_r;
  assign out_line_char = (kind_r == cla_pkg::KIND_ERR) ? 8'h00 : rd_data;

  always_comb begin
    is_end   = in_rx_byte inside {cla_pkg::CH_CR, cla_pkg::CH_LF};
    is_erase = in_rx_byte inside {cla_pkg::CH_BS, cla_pkg::CH_DEL};
  end

  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    skip_nxt      = skip_r;
    idx_nxt       = idx_r;
    n_nxt         = n_r;
    out_valid_nxt = out_valid_r && out_stall;
    kind_nxt      = kind_r;
    last_nxt      = last_r;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (is_end) begin
            if (skip_r || (len_r == '0)) begin
              skip_nxt = 1'b0;
            end else begin
              state_nxt = ST_STREAM;
              n_nxt     = len_r;
              idx_nxt   = '0;
              len_nxt   = '0;
              skip_nxt  = 1'b1;
            end
          end else if (is_erase) begin
            if (len_r != '0) begin
              len_nxt = len_r - LEN_ONE;
            end
          end else if (len_r < LAST_IDX) begin
            wr_en    = 1'b1;
            skip_nxt = 1'b0;
            len_nxt  = len_r + LEN_ONE;
            if (in_rx_byte == cla_pkg::CH_QUERY) begin
              state_nxt = ST_STREAM;
              n_nxt     = len_r + LEN_ONE;
              idx_nxt   = '0;
              len_nxt   = '0;
              skip_nxt  = 1'b1;
            end
          end else begin
            len_nxt       = '0;
            out_valid_nxt = 1'b1;
            kind_nxt      = cla_pkg::KIND_ERR;
            last_nxt      = 1'b1;
          end
        end
      end
      ST_STREAM: begin
        if (!out_valid_r || !out_stall) begin
          rd_en         = 1'b1;
          out_valid_nxt = 1'b1;
          kind_nxt      = cla_pkg::KIND_CHAR;
          last_nxt      = (idx_r == (n_r - LEN_ONE));
          idx_nxt       = idx_r + LEN_ONE;
          if (idx_r == (n_r - LEN_ONE)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      skip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      skip_r      <= skip_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    n_r    <= n_nxt;
    kind_r <= kind_nxt;
    last_r <= last_nxt;
  end

  cla_ram #(
    .WIDTH (8),
    .DEPTH (LINE_SIZE)
  ) u_line_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (len_r),
    .wr_data   (in_rx_byte),
    .rd_en     (rd_en),
    .rd_addr   (idx_r),
    .rd_data_r (rd_data)
  );

`include "command_line_assembler_assert.svh"

  `CLA_ASSERT_ALWAYS(a_len_in_range, len_r <= LAST_IDX)
  `CLA_ASSERT_IMPLIES(a_err_is_last, out_valid_r && (kind_r == cla_pkg::KIND_ERR), last_r)
  `CLA_ASSERT_IMPLIES(a_stream_cleared, state_r == ST_STREAM, (len_r == '0) && skip_r)
  `CLA_ASSERT_NEXT(a_query_runs,
    in_xfer && (in_rx_byte == cla_pkg::CH_QUERY) && (len_r < LAST_IDX),
    state_r == ST_STREAM)

endmodule

/* test/tb_top.sv */
module tb_top;

  localparam int LINE_SIZE = cla_pkg::LINE_SIZE_DEF;
  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_HOLD = 300;

  typedef struct packed {
    logic       kind;
    logic [7:0] ch;
    logic       last;
  } line_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_kind;
  logic [7:0] out_line_char;
  logic       out_last;

  command_line_assembler uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_rx_byte(in_rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_kind(out_kind),
    .out_line_char(out_line_char),
    .out_last(out_last)
  );

  logic [7:0]   rx_pending_q[$];
  line_result_t expected_line_q[$];

  logic [7:0] line_buf[LINE_SIZE];
  logic [5:0] line_len = '0;
  logic       skip_end = 1'b0;

  int shown_cnt = 0;
  int taken_cnt = 0;
  int pushed_cnt = 0;
  int error_cnt = 0;
  int quiet_cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic void flush_line();
    if (line_len == 0) begin
      skip_end = 1'b0;
    end else begin
      for (int k = 0; k < int'(line_len); k++) begin
        expected_line_q.push_back('{cla_pkg::KIND_CHAR, line_buf[k],
                                    (k + 1 == int'(line_len))});
      end
      line_len = '0;
      skip_end = 1'b1;
    end
  endfunction

  function automatic void assemble_byte(input logic [7:0] b);
    if (b == cla_pkg::CH_CR || b == cla_pkg::CH_LF) begin
      if (skip_end) begin
        skip_end = 1'b0;
      end else begin
        flush_line();
      end
    end else if (b == cla_pkg::CH_BS || b == cla_pkg::CH_DEL) begin
      if (line_len != 0) begin
        line_len = line_len - 1'b1;
      end
    end else if (int'(line_len) + 1 < LINE_SIZE) begin
      skip_end = 1'b0;
      line_buf[line_len] = b;
      line_len = line_len + 1'b1;
      if (b == cla_pkg::CH_QUERY) begin
        flush_line();
      end
    end else begin
      line_len = '0;
      expected_line_q.push_back('{cla_pkg::KIND_ERR, 8'h00, 1'b1});
    end
  endfunction

  function automatic void push_byte(input logic [7:0] b);
    rx_pending_q.push_back(b);
    pushed_cnt++;
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      push_byte(s[i]);
    end
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(255));
    end while (c == cla_pkg::CH_CR || c == cla_pkg::CH_LF || c == cla_pkg::CH_BS ||
               c == cla_pkg::CH_DEL || c == cla_pkg::CH_QUERY);
    return c;
  endfunction

  function automatic void push_chunk();
    int sel;
    int n;
    sel = $urandom_range(99);
    if (sel < 65) begin
      n = $urandom_range(10, 1);
      for (int i = 0; i < n; i++) begin
        push_byte(plain_char());
        if ($urandom_range(9) == 0) begin
          push_byte($urandom_range(1) ? cla_pkg::CH_BS : cla_pkg::CH_DEL);
        end
      end
      case ($urandom_range(3))
        0: begin
          push_byte(cla_pkg::CH_CR);
        end
        1: begin
          push_byte(cla_pkg::CH_LF);
        end
        2: begin
          push_byte(cla_pkg::CH_CR);
          push_byte(cla_pkg::CH_LF);
        end
        default: begin
          push_byte(cla_pkg::CH_QUERY);
          if ($urandom_range(1)) begin
            push_byte($urandom_range(1) ? cla_pkg::CH_CR : cla_pkg::CH_LF);
          end
        end
      endcase
    end else if (sel < 75) begin
      n = $urandom_range(6, 1);
      for (int i = 0; i < n; i++) begin
        push_byte(8'($urandom_range(255)));
      end
    end else if (sel < 85) begin
      n = $urandom_range(4, 1);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(3))
          0: push_byte(cla_pkg::CH_BS);
          1: push_byte(cla_pkg::CH_DEL);
          2: push_byte(cla_pkg::CH_CR);
          default: push_byte(cla_pkg::CH_LF);
        endcase
      end
    end else begin
      n = LINE_SIZE - 1;
      if (sel >= 93) begin
        n = n + $urandom_range(4, 1);
      end
      for (int i = 0; i < n; i++) begin
        push_byte(plain_char());
      end
      push_byte($urandom_range(1) ? cla_pkg::CH_CR : cla_pkg::CH_LF);
    end
  endfunction

  // sender: hold an offered byte until its transfer
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && taken_cnt != shown_cnt) begin
      in_valid <= 1'b1;
    end else if (rx_pending_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
      in_valid <= 1'b1;
      in_rx_byte <= rx_pending_q.pop_front();
      shown_cnt = shown_cnt + 1;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver: random stall, or a long hold-off on request
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_ack != hold_req) begin
      out_stall <= 1'b1;
      hold_ack <= hold_ack + 1;
      hold_left <= LONG_HOLD;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    line_result_t exp_r;
    logic         moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        assemble_byte(in_rx_byte);
        taken_cnt = taken_cnt + 1;
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (expected_line_q.size() == 0) begin
          error_cnt++;
          $display("%0t: unexpected result kind %0d char %h last %0d", $time,
                   out_kind, out_line_char, out_last);
        end else begin
          exp_r = expected_line_q.pop_front();
          if (out_kind !== exp_r.kind) begin
            error_cnt++;
            $display("%0t: kind expected %0d got %0d", $time, exp_r.kind, out_kind);
          end
          if (out_line_char !== exp_r.ch) begin
            error_cnt++;
            $display("%0t: line_char expected %h got %h", $time, exp_r.ch, out_line_char);
          end
          if (out_last !== exp_r.last) begin
            error_cnt++;
            $display("%0t: last expected %0d got %0d", $time, exp_r.last, out_last);
          end
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  task automatic drain();
    wait (rx_pending_q.size() == 0 && taken_cnt == shown_cnt && expected_line_q.size() == 0);
    @(posedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // no idling, with one long receiver hold-off
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 1;
    push_byte(cla_pkg::CH_CR);
    push_byte(cla_pkg::CH_LF);
    push_byte(cla_pkg::CH_BS);
    push_byte(cla_pkg::CH_DEL);
    push_text("A");
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h80);
    push_byte(cla_pkg::CH_BS);
    push_byte(cla_pkg::CH_CR);
    push_byte(cla_pkg::CH_LF);
    push_byte(8'h78);
    push_byte(cla_pkg::CH_QUERY);
    push_byte(cla_pkg::CH_CR);
    push_byte(cla_pkg::CH_LF);
    push_byte(cla_pkg::CH_QUERY);
    push_byte(8'h62);
    push_byte(cla_pkg::CH_DEL);
    push_byte(cla_pkg::CH_CR);
    while (pushed_cnt < 60) begin
      push_chunk();
    end
    drain();

    idle_pct = 84;
    stall_pct = 0;
    while (pushed_cnt < 105) begin
      push_chunk();
    end
    drain();

    idle_pct = 0;
    stall_pct = 84;
    while (pushed_cnt < 150) begin
      push_chunk();
    end
    drain();

    idle_pct = 6;
    stall_pct = 6;
    while (pushed_cnt < 195) begin
      push_chunk();
    end
    drain();

    repeat (20) @(posedge clk);
    if (error_cnt == 0 && expected_line_q.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/cla_pkg.sv
src/cla_ram.sv
src/command_line_assembler.sv
test/tb_top.sv
